[rtl/upc_pkg.sv]
// Shared types, character constants and helper functions for the percent codec.
package upc_pkg;

	typedef enum logic [1:0] {
		ST_DATA      = 2'd0,
		ST_BROKEN    = 2'd1,
		ST_ABORT_END = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_PASS = 2'd0,
		PH_PCT  = 2'd1,
		PH_HEX1 = 2'd2,
		PH_DROP = 2'd3
	} phase_t;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} mode_t;

	// Work handed from front to back: a single result or a three-byte escape.
	typedef struct packed {
		logic       esc;
		logic [7:0] data;
		status_t    status;
		logic       last;
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LZ    = 8'h7a;

	localparam logic [1:0] PIECE_PCT = 2'd0;
	localparam logic [1:0] PIECE_HI  = 2'd1;
	localparam logic [1:0] PIECE_LO  = 2'd2;

	function automatic logic is_plain(input logic [7:0] b);
		return (b >= CH_0 && b <= CH_9) || (b >= CH_UA && b <= CH_UZ) ||
			(b >= CH_LA && b <= CH_LZ) || b == CH_DOT || b == CH_COMMA ||
			b == CH_DASH || b == CH_UNDER;
	endfunction

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h = '0;
		if (b >= CH_0 && b <= CH_9) begin
			h.ok  = 1'b1;
			h.val = 4'(b - CH_0);
		end else if (b >= CH_LA && b <= CH_LF) begin
			h.ok  = 1'b1;
			h.val = 4'(b - CH_LA + 8'd10);
		end else if (b >= CH_UA && b <= CH_UF) begin
			h.ok  = 1'b1;
			h.val = 4'(b - CH_UA + 8'd10);
		end
		return h;
	endfunction

	// Lowercase hex digit character.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (CH_0 + {4'd0, n}) : (CH_LA + {4'd0, n} - 8'd10);
	endfunction

endpackage

[rtl/upc_front.sv]
// Front end: accepts input bytes, tracks decode state, classifies into jobs.
module upc_front import upc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mode_t      mode,
	input  logic       cfg_clear,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       q_full,
	output logic       push,
	output job_t       push_job
);

	phase_t     phase_q, phase_d;
	logic [3:0] nib_q, nib_d;
	logic       accept;
	logic       broken;
	hex_t       hv;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;
	assign hv       = hex_decode(in_byte);

	always_comb begin
		push     = 1'b0;
		push_job = '0;
		phase_d  = phase_q;
		nib_d    = nib_q;
		broken   = 1'b0;
		if (mode == MODE_ENCODE) begin
			push          = 1'b1;
			push_job.esc  = ~is_plain(in_byte);
			push_job.data = in_byte;
			push_job.last = in_last;
		end else begin
			case (phase_q)
				PH_PASS: begin
					if (in_byte == CH_PCT) begin
						if (in_last) broken = 1'b1;
						else phase_d = PH_PCT;
					end else begin
						push          = 1'b1;
						push_job.data = in_byte;
						push_job.last = in_last;
					end
				end
				PH_PCT: begin
					if (hv.ok && !in_last) begin
						nib_d   = hv.val;
						phase_d = PH_HEX1;
					end else begin
						broken = 1'b1;
					end
				end
				PH_HEX1: begin
					if (hv.ok) begin
						push          = 1'b1;
						push_job.data = {nib_q, hv.val};
						push_job.last = in_last;
						phase_d       = PH_PASS;
					end else begin
						broken = 1'b1;
					end
				end
				default: begin
					if (in_last) begin
						push            = 1'b1;
						push_job.status = ST_ABORT_END;
						push_job.last   = 1'b1;
						phase_d         = PH_PASS;
					end
				end
			endcase
			if (broken) begin
				push            = 1'b1;
				push_job.status = ST_BROKEN;
				push_job.last   = in_last;
				phase_d         = in_last ? PH_PASS : PH_DROP;
			end
		end
		push = push & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PASS;
			nib_q   <= '0;
		end else if (cfg_clear) begin
			phase_q <= PH_PASS;
			nib_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			nib_q   <= nib_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_ENCODE && !cfg_clear) |=> $stable(phase_q))
		else $error("decode phase moved in encode mode");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_job.esc) |-> (mode == MODE_ENCODE))
		else $error("escape job issued while decoding");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_job.status != ST_DATA) |-> (push_job.data == 8'd0))
		else $error("error job carries a nonzero byte");

endmodule

[rtl/upc_fifo.sv]
// Small register queue of jobs between front and back end.
module upc_fifo import upc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == FULL_CNT);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL_CNT)
		else $error("queue count overflow");

endmodule

[rtl/upc_back.sv]
// Back end: expands jobs into result bytes through one output register.
module upc_back import upc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       out_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	status_t    status_q;
	logic       last_q;
	logic       load;
	logic       final_piece;
	logic [7:0] byte_d;
	logic       last_d;

	assign load        = ~empty & (~out_valid_q | ~out_stall);
	assign final_piece = ~head.esc | (idx_q == PIECE_LO);
	assign pop         = load & final_piece;

	always_comb begin
		byte_d = head.data;
		last_d = head.last;
		if (head.esc) begin
			case (idx_q)
				PIECE_PCT: byte_d = CH_PCT;
				PIECE_HI:  byte_d = hex_char(head.data[7:4]);
				default:   byte_d = hex_char(head.data[3:0]);
			endcase
			last_d = head.last & (idx_q == PIECE_LO);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= PIECE_PCT;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= final_piece ? PIECE_PCT : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= byte_d;
			status_q <= head.status;
			last_q   <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign status    = status_q;
	assign out_last  = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != PIECE_PCT) |-> (!empty && head.esc))
		else $error("escape piece count without escape job");
	assert property (@(posedge clk) disable iff (!arst_n) idx_q != 2'd3)
		else $error("escape piece count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && head.esc && idx_q != PIECE_LO) |=> !out_last)
		else $error("last flag on a leading escape byte");

endmodule

[rtl/url_percent_codec.sv]
// Top level of the URL percent encoder/decoder.
// Percent codec for a byte stream. With mode = 0 (encode) letters, digits and . , - _ pass
// through and every other byte, 0x80 and up included, leaves as '%' plus two lowercase
// hex digits. With mode = 1 (decode) '%' and two hex digits (either case) become one byte,
// anything else passes. A bad hex digit gives a result with status 1 and the rest of the
// message is dropped; the dropped last byte gives status 2. '%' or a first hex digit that
// carries in_last gives status 1 with out_last set. in_last marks message ends, so byte
// 0xFF is ordinary data. Timing: the front end takes one request per cycle while in_stall
// is low and files its job, if any, in a DEPTH-entry job queue; the back end drives one
// result per cycle through its output register while out_stall is low. A pass-through
// byte gives one output byte, an encoded escape three, so the output register sets the
// sustained rate: one request per cycle for plain traffic; escaped traffic fills the
// queue and stalls requests. A result passes through the job queue, then the output
// register. Bytes that give no result (a '%' or first hex digit, dropped bytes) put no
// job in the queue. Writing mode (register 0, addresses 0 to 3) clears the decode state,
// also when the value is unchanged; write it only between messages with the block drained.
module url_percent_codec import upc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request side
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	// result side
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic        out_last
);

	mode_t mode_q;
	logic  cfg_wr;
	logic  push, pop, q_empty, q_full;
	job_t  push_job, head;

	// Register file: a single mode bit at byte addresses 0 to 3 (paddr[2] low).
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
		end else if (cfg_wr) begin
			mode_q <= mode_t'(pwdata[0]);
		end
	end

	upc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (mode_q),
		.cfg_clear(cfg_wr),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// Decouples classification from result expansion.
	upc_fifo #(.DEPTH(DEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	upc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.status   (status),
		.out_last (out_last)
	);

endmodule
